### rtl/lcsd_pkg.sv
// Shared types and constants for the LED cursor serial driver.
`timescale 1ns / 1ps
package lcsd_pkg;

  localparam int MAX_LEDS_DEF  = 32;
  localparam int CNT_W         = 6;
  localparam int CUR_W         = 6;
  localparam int IDX_W         = 8;
  localparam int NBYTE_W       = 3;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [CNT_W-1:0] LED_COUNT_RST = CNT_W'(8);
  localparam logic [CUR_W-1:0] CURSOR_RST    = '1;

  // register index, taken from paddr[2]
  localparam logic REG_LED_COUNT = 1'b0;

  typedef enum logic [1:0] {
    FUNC_FWD   = 2'd0,
    FUNC_BACK  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    logic               fire;
    logic [NBYTE_W-1:0] nbytes;
  } load_t;

endpackage

### rtl/lcsd_ifs.sv
// Valid/ready channel interfaces for command words and serial result words.
`timescale 1ns / 1ps
interface lcsd_in_if import lcsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [IDX_W-1:0] led_index;
  logic             bit_value;
  logic             turn_off_old;

  modport source (output valid, func, led_index, bit_value, turn_off_old, input ready);
  modport sink   (input valid, func, led_index, bit_value, turn_off_old, output ready);
endinterface

interface lcsd_out_if ();
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_now;

  modport source (output valid, serial_bit, latch_now, input ready);
  modport sink   (input valid, serial_bit, latch_now, output ready);
endinterface

### rtl/led_cursor_serial_driver.sv
// Top level of the LED cursor serial driver.
// A command word that changes the LED pattern is answered by a burst of
// 8*ceil(count/8) serial words (8, 16, 24 or 32), highest byte first and
// MSB first, with latch_now set on the last word; the shift register sends
// one word per cycle while out_chan.ready is high, and in_chan.ready stays
// low until the last word is taken. A command that does not take effect
// is accepted and produces no word.
`timescale 1ns / 1ps
module led_cursor_serial_driver import lcsd_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lcsd_in_if.sink           in_chan,
  lcsd_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int PAT_W = ((MAX_LEDS + 7) / 8) * 8;

  logic [CNT_W-1:0] led_count;
  logic [PAT_W-1:0] pattern_nxt;
  load_t            load;
  logic             busy;
  logic             in_accept;

  assign in_chan.ready = !busy;
  assign in_accept     = in_chan.valid && in_chan.ready;

  lcsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .led_count (led_count)
  );

  lcsd_core #(.MAX_LEDS(MAX_LEDS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .func         (in_chan.func),
    .led_index    (in_chan.led_index),
    .bit_value    (in_chan.bit_value),
    .turn_off_old (in_chan.turn_off_old),
    .led_count    (led_count),
    .load         (load),
    .pattern_nxt  (pattern_nxt)
  );

  lcsd_shifter #(.MAX_LEDS(MAX_LEDS)) u_shifter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .pattern    (pattern_nxt),
    .busy       (busy),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .serial_bit (out_chan.serial_bit),
    .latch_now  (out_chan.latch_now)
  );

  a_no_accept_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("command accepted during a burst");

  a_latch_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.latch_now) |=> !out_chan.valid)
    else $error("burst continues after latch word");

  a_clear_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_chan.func == FUNC_CLEAR)) |=> out_chan.valid)
    else $error("clear command produced no burst");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load.fire |-> !busy)
    else $error("pattern loaded while shifting");

endmodule

### rtl/lcsd_cfg.sv
// APB-style configuration register holding the LED count.
`timescale 1ns / 1ps
module lcsd_cfg import lcsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  led_count
);

  logic [CNT_W-1:0] led_count_r;
  logic             wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && (paddr[2] == REG_LED_COUNT);
  assign led_count = led_count_r;
  assign prdata    = (paddr[2] == REG_LED_COUNT) ? CFG_DW'(led_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
    end else if (wr_en) begin
      led_count_r <= pwdata[CNT_W-1:0];
    end
  end

endmodule

### rtl/lcsd_core.sv
// Command decode, cursor and LED pattern update.
`timescale 1ns / 1ps
module lcsd_core import lcsd_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF,
  localparam int PAT_W   = ((MAX_LEDS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       func,
  input  logic [IDX_W-1:0] led_index,
  input  logic             bit_value,
  input  logic             turn_off_old,
  input  logic [CNT_W-1:0] led_count,
  output load_t            load,
  output logic [PAT_W-1:0] pattern_nxt
);

  logic [PAT_W-1:0] pattern_r;
  logic [CUR_W-1:0] cursor_r;
  logic [CUR_W-1:0] cursor_nxt;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_m1;
  logic             effective;
  logic             fwd_ok;
  logic             back_ok;
  logic             idx_ok;

  always_comb begin
    if (led_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (led_count > CNT_W'(MAX_LEDS)) begin
      cnt_eff = CNT_W'(MAX_LEDS);
    end else begin
      cnt_eff = led_count;
    end
    cnt_m1  = cnt_eff - CNT_W'(1);
    fwd_ok  = $signed({cursor_r[CUR_W-1], cursor_r}) < $signed({2'b00, cnt_m1});
    back_ok = $signed(cursor_r) > $signed(CUR_W'(0));
    idx_ok  = led_index < IDX_W'(cnt_eff);
  end

  always_comb begin
    effective   = 1'b0;
    cursor_nxt  = cursor_r;
    pattern_nxt = pattern_r;
    unique case (func_t'(func))
      FUNC_FWD: begin
        effective  = fwd_ok;
        cursor_nxt = cursor_r + CUR_W'(1);
        for (int i = 0; i < PAT_W; i++) begin
          if (turn_off_old && (cursor_r == CUR_W'(i))) pattern_nxt[i] = 1'b0;
          if (cursor_nxt == CUR_W'(i)) pattern_nxt[i] = 1'b1;
        end
      end
      FUNC_BACK: begin
        effective  = back_ok;
        cursor_nxt = cursor_r - CUR_W'(1);
        for (int i = 0; i < PAT_W; i++) begin
          if (turn_off_old && (cursor_r == CUR_W'(i))) pattern_nxt[i] = 1'b0;
          if (cursor_nxt == CUR_W'(i)) pattern_nxt[i] = 1'b1;
        end
      end
      FUNC_WRITE: begin
        effective = idx_ok;
        for (int i = 0; i < PAT_W; i++) begin
          if (led_index == IDX_W'(i)) pattern_nxt[i] = bit_value;
        end
      end
      FUNC_CLEAR: begin
        effective   = 1'b1;
        cursor_nxt  = CURSOR_RST;
        pattern_nxt = '0;
      end
      default: begin
        effective = 1'b0;
      end
    endcase
  end

  assign load.fire   = accept && effective;
  assign load.nbytes = NBYTE_W'(cnt_m1 >> 3) + NBYTE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      cursor_r  <= CURSOR_RST;
    end else if (load.fire) begin
      pattern_r <= pattern_nxt;
      cursor_r  <= cursor_nxt;
    end
  end

endmodule

### rtl/lcsd_shifter.sv
// Parallel-load shift register that sends the pattern one bit per word.
`timescale 1ns / 1ps
module lcsd_shifter import lcsd_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF,
  localparam int PAT_W     = ((MAX_LEDS + 7) / 8) * 8,
  localparam int PAT_BYTES = PAT_W / 8,
  localparam int SH_W      = $clog2(PAT_W),
  localparam int REM_W     = $clog2(PAT_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  load_t            load,
  input  logic [PAT_W-1:0] pattern,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             serial_bit,
  output logic             latch_now
);

  logic [PAT_W-1:0]   shreg_r;
  logic [PAT_W-1:0]   shreg_nxt;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W-1:0]   rem_nxt;
  logic [NBYTE_W-1:0] gap;
  logic [SH_W-1:0]    shamt;

  assign busy       = (rem_r != '0);
  assign out_valid  = busy;
  assign serial_bit = shreg_r[PAT_W-1];
  assign latch_now  = (rem_r == REM_W'(1));

  always_comb begin
    gap       = NBYTE_W'(PAT_BYTES) - load.nbytes;
    shamt     = SH_W'({gap, 3'b000});
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    if (load.fire) begin
      shreg_nxt = pattern << shamt;
      rem_nxt   = REM_W'({load.nbytes, 3'b000});
    end else if (out_valid && out_ready) begin
      shreg_nxt = {shreg_r[PAT_W-2:0], 1'b0};
      rem_nxt   = rem_r - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

### bench/led_cursor_serial_driver_tb.sv
// Self-checking testbench for the LED cursor serial driver: command words in, serial words out.
`timescale 1ns / 1ps
module led_cursor_serial_driver_tb;
  import lcsd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYC = 4;
  localparam int NPHASE     = 12;
  localparam int PHASE_CMDS = 38;
  localparam logic [CFG_AW-1:0] LED_COUNT_ADDR = CFG_AW'({REG_LED_COUNT, 2'b00});

  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] led_index;
    logic             bit_value;
    logic             turn_off_old;
  } led_cmd_t;

  // typed rows carry the pattern and burst length expected at reset count
  typedef struct packed {
    led_cmd_t    cmd;
    logic        typed;
    logic [7:0]  exp_pat;
    logic [5:0]  exp_bits;
  } dir_row_t;

  typedef struct {
    logic serial_bit;
    logic latch_now;
  } shift_word_t;

  localparam int NDIR = 24;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    '{'{FUNC_BACK,  8'd0,   1'b0, 1'b1}, 1'b1, 8'h00, 6'd0},  // back from start: ignored
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b0}, 1'b1, 8'h01, 6'd8},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b1, 8'h02, 6'd8},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b0}, 1'b1, 8'h06, 6'd8},
    '{'{FUNC_BACK,  8'd0,   1'b0, 1'b1}, 1'b1, 8'h02, 6'd8},
    '{'{FUNC_BACK,  8'd0,   1'b0, 1'b0}, 1'b1, 8'h03, 6'd8},
    '{'{FUNC_BACK,  8'd0,   1'b0, 1'b1}, 1'b1, 8'h00, 6'd0},  // cursor at zero
    '{'{FUNC_WRITE, 8'd7,   1'b1, 1'b0}, 1'b1, 8'h83, 6'd8},
    '{'{FUNC_WRITE, 8'd8,   1'b1, 1'b1}, 1'b1, 8'h00, 6'd0},  // index == count
    '{'{FUNC_WRITE, 8'd255, 1'b1, 1'b0}, 1'b1, 8'h00, 6'd0},
    '{'{FUNC_WRITE, 8'd0,   1'b0, 1'b0}, 1'b1, 8'h82, 6'd8},
    '{'{FUNC_CLEAR, 8'd255, 1'b1, 1'b1}, 1'b1, 8'h00, 6'd8},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b1, 8'h01, 6'd8},  // nothing to clear at start
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_FWD,   8'd0,   1'b0, 1'b1}, 1'b1, 8'h80, 6'd8},
    '{'{FUNC_FWD,   8'd0,   1'b1, 1'b0}, 1'b1, 8'h00, 6'd0},  // cursor at count-1
    '{'{FUNC_WRITE, 8'd3,   1'b1, 1'b1}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_BACK,  8'd170, 1'b1, 1'b0}, 1'b0, 8'h00, 6'd0},
    '{'{FUNC_CLEAR, 8'd0,   1'b0, 1'b0}, 1'b1, 8'h00, 6'd8}
  };

  localparam logic [5:0] PHASE_CNT [10] = '{
    6'd1, 6'd32, 6'd0, 6'd8, 6'd63, 6'd17, 6'd33, 6'd9, 6'd24, 6'd2
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lcsd_in_if  in_ch ();
  lcsd_out_if out_ch ();

  led_cursor_serial_driver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted block state
  logic [31:0] pat_q;
  int          cur_q;
  logic [5:0]  cnt_reg;

  shift_word_t shift_q[$];
  int          err_cnt;
  bit          tx_steady;
  bit          rx_steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_count();
    if (cnt_reg == 6'd0) return 1;
    if (cnt_reg > 6'(MAX_LEDS_DEF)) return MAX_LEDS_DEF;
    return int'(cnt_reg);
  endfunction

  function automatic int burst_bits();
    return ((eff_count() - 1) / 8 + 1) * 8;
  endfunction

  // updates pattern and cursor; returns 1 when the command takes effect
  function automatic bit apply_led_cmd(led_cmd_t c);
    int n;
    n = eff_count();
    case (c.func)
      FUNC_FWD: begin
        if (cur_q >= n - 1) return 1'b0;
        if (c.turn_off_old && cur_q >= 0) pat_q[cur_q] = 1'b0;
        cur_q++;
        pat_q[cur_q] = 1'b1;
      end
      FUNC_BACK: begin
        if (cur_q <= 0) return 1'b0;
        if (c.turn_off_old) pat_q[cur_q] = 1'b0;
        cur_q--;
        pat_q[cur_q] = 1'b1;
      end
      FUNC_WRITE: begin
        if (int'(c.led_index) >= n) return 1'b0;
        pat_q[c.led_index[4:0]] = c.bit_value;
      end
      default: begin
        pat_q = '0;
        cur_q = -1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void queue_shift_out(logic [31:0] pat, int nbits);
    shift_word_t w;
    for (int i = nbits - 1; i >= 0; i--) begin
      w.serial_bit = pat[i];
      w.latch_now  = (i == 0);
      shift_q.push_back(w);
    end
  endfunction

  function automatic led_cmd_t rand_led_cmd(int fwd_pct);
    led_cmd_t c;
    int       r;
    r = $urandom_range(0, 99);
    if (r < fwd_pct) c.func = FUNC_FWD;
    else if (r < fwd_pct + 25) c.func = FUNC_BACK;
    else if (r < 95) c.func = FUNC_WRITE;
    else c.func = FUNC_CLEAR;
    if ($urandom_range(0, 3) == 0) c.led_index = IDX_W'($urandom_range(0, 255));
    else c.led_index = IDX_W'($urandom_range(0, eff_count() - 1));
    c.bit_value    = 1'($urandom_range(0, 1));
    c.turn_off_old = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // returns at the edge the word is taken; valid is left high
  task automatic send_cmd(led_cmd_t c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= c.func;
    in_ch.led_index    <= c.led_index;
    in_ch.bit_value    <= c.bit_value;
    in_ch.turn_off_old <= c.turn_off_old;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shift_q.size() != 0) @(posedge clk);
  endtask

  // write led_count, then read it back
  task automatic set_led_count(logic [CFG_DW-1:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LED_COUNT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cnt_reg = wdata[5:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(cnt_reg)) begin
      $error("led_count readback: expected %0d, actual %0d", cnt_reg, cfg_prdata);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: random stalls, compare each word with the oldest expectation
  initial begin
    int          stall;
    shift_word_t w;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (shift_q.size() == 0) begin
        $error("unexpected word: serial_bit=%0b latch_now=%0b",
               out_ch.serial_bit, out_ch.latch_now);
        err_cnt++;
      end else begin
        w = shift_q.pop_front();
        if (out_ch.serial_bit !== w.serial_bit) begin
          $error("serial_bit: expected %0b, actual %0b", w.serial_bit, out_ch.serial_bit);
          err_cnt++;
        end
        if (out_ch.latch_now !== w.latch_now) begin
          $error("latch_now: expected %0b, actual %0b", w.latch_now, out_ch.latch_now);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable))
        idle = 0;
      else
        idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    led_cmd_t         c;
    logic [CFG_DW-1:0] wdata;
    int               fwd_pct;
    err_cnt   = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    pat_q     = '0;
    cur_q     = -1;
    cnt_reg   = LED_COUNT_RST;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_FWD;
    in_ch.led_index    <= '0;
    in_ch.bit_value    <= 1'b0;
    in_ch.turn_off_old <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      send_cmd(DIR_ROWS[i].cmd);
      if (DIR_ROWS[i].typed) begin
        void'(apply_led_cmd(DIR_ROWS[i].cmd));
        if (DIR_ROWS[i].exp_bits != 0)
          queue_shift_out({24'd0, DIR_ROWS[i].exp_pat}, int'(DIR_ROWS[i].exp_bits));
      end else if (apply_led_cmd(DIR_ROWS[i].cmd)) begin
        queue_shift_out(pat_q, burst_bits());
      end
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      drain_results();
      repeat (SETTLE_CYC) @(posedge clk);
      wdata = $urandom();
      wdata[5:0] = (ph < 10) ? PHASE_CNT[ph] : 6'($urandom_range(0, 63));
      set_led_count(wdata);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 4 == 3);
      fwd_pct   = (ph % 2 == 1) ? 55 : 35;
      for (int i = 0; i < PHASE_CMDS; i++) begin
        c = rand_led_cmd(fwd_pct);
        send_cmd(c);
        if (apply_led_cmd(c)) queue_shift_out(pat_q, burst_bits());
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (shift_q.size() != 0) begin
      $error("%0d expected words never arrived", shift_q.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
